// File: rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned StepWidth  = $clog2(ValueWidth);
  localparam int unsigned CountWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0]  AsciiZero   = 6'd48;
  localparam logic [DigitWidth-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitWidth-1:0] DabbleAdd   = 4'd3;

  typedef logic [NumDigits-1:0][DigitWidth-1:0] digits_t;

  // converter to emitter handoff
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } conv_result_t;

endpackage

// File: rtl/bda_front.sv
// ----------------------------------------------------------------------------
// bda_front
// Input side: accepts items and holds them in a short queue for the converter.
// ----------------------------------------------------------------------------
module bda_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bda_pkg::ValueWidth-1:0]  value_i,
  output logic                            q_valid_o,
  input  logic                            q_pop_i,
  output logic [bda_pkg::ValueWidth-1:0]  q_value_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [bda_pkg::ValueWidth-1:0] store_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = (cnt_q != CntWidth'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_value_o  = store_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

// File: rtl/bda_convert.sv
// ----------------------------------------------------------------------------
// bda_convert
// Double-dabble engine: one shift-and-add-3 step per cycle over all 64 bits.
// ----------------------------------------------------------------------------
module bda_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  logic [bda_pkg::ValueWidth-1:0]  q_value_i,
  output bda_pkg::conv_result_t           res_o,
  input  logic                            res_ready_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic [bda_pkg::StepWidth-1:0]  step_q, step_d;
  logic [bda_pkg::ValueWidth-1:0] value_q;
  bda_pkg::digits_t               digits_q, adjusted;
  logic [bda_pkg::NumDigits*bda_pkg::DigitWidth-1:0] adjusted_bits;

  assign q_pop_o       = (state_q == StIdle);
  assign res_o.valid   = (state_q == StDone);
  assign res_o.digits  = digits_q;
  assign adjusted_bits = adjusted;

  always_comb begin
    for (int i = 0; i < bda_pkg::NumDigits; i++) begin
      adjusted[i] = (digits_q[i] >= bda_pkg::DabbleLimit) ?
                    digits_q[i] + bda_pkg::DabbleAdd : digits_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          state_d = StRun;
          step_d  = '0;
        end
      end
      StRun: begin
        step_d = step_q + 1'b1;
        if (step_q == bda_pkg::StepWidth'(bda_pkg::ValueWidth - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) begin
      value_q  <= q_value_i;
      digits_q <= '0;
    end else if (state_q == StRun) begin
      value_q  <= {value_q[bda_pkg::ValueWidth-2:0], 1'b0};
      digits_q <= {adjusted_bits[bda_pkg::NumDigits*bda_pkg::DigitWidth-2:0],
                   value_q[bda_pkg::ValueWidth-1]};
    end
  end

endmodule

// File: rtl/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit
// Digit streamer: drops leading zeros, then sends one ASCII digit per item.
// ----------------------------------------------------------------------------
module bda_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bda_pkg::conv_result_t          res_i,
  output logic                           res_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bda_pkg::CharWidth-1:0]  digit_char_o,
  output logic                           last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSkip,
    StSend
  } state_e;

  localparam logic [bda_pkg::CountWidth-1:0] CountFull =
    bda_pkg::CountWidth'(bda_pkg::NumDigits);
  localparam logic [bda_pkg::CountWidth-1:0] CountOne = bda_pkg::CountWidth'(1);

  state_e                          state_q;
  logic [bda_pkg::CountWidth-1:0]  remain_q;
  bda_pkg::digits_t                digits_q;
  logic [bda_pkg::DigitWidth-1:0]  top_digit;
  logic                            out_valid_q, out_last_q;
  logic [bda_pkg::CharWidth-1:0]   out_char_q;
  logic                            load_out;

  assign top_digit    = digits_q[bda_pkg::NumDigits-1];
  assign res_ready_o  = (state_q == StIdle);
  assign load_out     = (state_q == StSend) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (res_i.valid) begin
            state_q  <= StSkip;
            remain_q <= CountFull;
          end
        end
        StSkip: begin
          if (top_digit == '0 && remain_q != CountOne) begin
            remain_q <= remain_q - 1'b1;
          end else begin
            state_q <= StSend;
          end
        end
        StSend: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            remain_q    <= remain_q - 1'b1;
            if (remain_q == CountOne) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && res_i.valid) begin
      digits_q <= res_i.digits;
    end else if ((state_q == StSkip && top_digit == '0 && remain_q != CountOne) ||
                 load_out) begin
      digits_q <= {digits_q[bda_pkg::NumDigits-2:0], bda_pkg::DigitWidth'(0)};
    end
    if (load_out) begin
      out_char_q <= bda_pkg::AsciiZero + bda_pkg::CharWidth'(top_digit);
      out_last_q <= (remain_q == CountOne);
    end
  end

endmodule

// File: rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 64-bit unsigned number to decimal ASCII digits, most significant
// first, leading zeros dropped, last flag on the final digit.
// ----------------------------------------------------------------------------
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    value_i[63:0]
// out      out_valid_o / out_ready_i  digit_char_o[5:0], last_o
//
// An item waits in the input queue, then passes through the converter
// (load, 64 double-dabble steps, handoff); the shift loop sets the rate
// while the output does not stall. Digit streaming overlaps the next
// conversion: the streamer loads a result, drops leading zeros one at a
// time, then sends one digit per cycle when out_ready_i stays high.
// Reset clears only control state. Output stalls back up through the
// streamer, converter and queue; in_ready_o drops when the queue is full.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bda_pkg::ValueWidth-1:0]  value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bda_pkg::CharWidth-1:0]   digit_char_o,
  output logic                            last_o
);

  logic                           q_valid, q_pop;
  logic [bda_pkg::ValueWidth-1:0] q_value;
  bda_pkg::conv_result_t          conv_res;
  logic                           conv_ready;

  bda_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_value_o  (q_value)
  );

  bda_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_value_i   (q_value),
    .res_o       (conv_res),
    .res_ready_i (conv_ready)
  );

  bda_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (conv_res),
    .res_ready_o  (conv_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

// File: rtl/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for binary_to_decimal_ascii, attached by bind.
// ----------------------------------------------------------------------------
module bda_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic [bda_pkg::ValueWidth-1:0]  value_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [bda_pkg::CharWidth-1:0]   digit_char_o,
  input  logic                            last_o
);

  localparam logic [bda_pkg::CharWidth-1:0] AsciiNine =
    bda_pkg::AsciiZero + bda_pkg::CharWidth'(9);

  logic                           out_fire;
  logic                           first_q;
  logic [bda_pkg::CountWidth-1:0] cnt_q;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      if (out_fire) begin
        first_q <= last_o;
        cnt_q   <= last_o ? '0 : cnt_q + 1'b1;
      end
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digit_char_o) && $stable(last_o))
    else $error("output item changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= bda_pkg::AsciiZero) && (digit_char_o <= AsciiNine))
    else $error("digit character out of range");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && first_q && (digit_char_o == bda_pkg::AsciiZero) |-> last_o)
    else $error("leading zero emitted");

  a_max_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (cnt_q == bda_pkg::CountWidth'(bda_pkg::NumDigits - 1)) |-> last_o)
    else $error("more than twenty digits in one number");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_o       (last_o)
);
